/* sv/positional_list_store_core_macros.svh */
// assertion macros shared by the list store
`ifndef POSITIONAL_LIST_STORE_CORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PLSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/plsc_pkg.sv */
package plsc_pkg;

  localparam int unsigned CAP_DEFAULT = 8;
  localparam int unsigned CAP_MAX     = 64;
  // wide enough for any count up to the largest capacity
  localparam int unsigned CNT_MAX_W   = $clog2(CAP_MAX + 1);
  localparam int unsigned WORD_W      = 32;

  typedef enum logic [1:0] {
    KIND_INS  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_FIND = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } cell_op_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e              op;
    logic [CNT_MAX_W-1:0]  tgt;
    logic [CNT_MAX_W-1:0]  cnt;
    logic [WORD_W-1:0]     word;
  } cell_ctrl_t;

endpackage

/* sv/plsc_req_if.sv */
interface plsc_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         position;
  logic signed [31:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

/* sv/plsc_rsp_if.sv */
interface plsc_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] removed_value;
  logic               found;
  logic [2:0]         found_index;
  logic [3:0]         count;

  modport source (output valid, status, removed_value, found, found_index, count,
                  input ready);
  modport sink   (input valid, status, removed_value, found, found_index, count,
                  output ready);
endinterface

/* sv/positional_list_store_core.sv */
// channel | dir | modport | payload
// --------+-----+---------+---------------------------------------------------
// req_i   | in  | sink    | kind, position, value
// rsp_o   | out | source  | status, removed_value, found, found_index, count
//
// one request per cycle unless stalled: the cell row shifts and compares on accept
// the result shows in the response register in the cycle after the transfer
// a new request is taken while the held response is being taken in the same cycle
// reset clears the entry count and the response valid; cell words stay unwritten
// a stalled response blocks further requests until it is taken
module positional_list_store_core #(
  parameter int unsigned Capacity = plsc_pkg::CAP_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plsc_req_if.sink   req_i,
  plsc_rsp_if.source rsp_o
);
  import plsc_pkg::*;

  `include "positional_list_store_core_macros.svh"

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  // compare width covering both the 3-bit position and the count
  localparam int unsigned CmpW = (CntW > 3) ? CntW : 3;

  // list occupancy
  logic [CntW-1:0] count_q, count_d;

  // response register
  logic            rsp_vld_q;
  status_e         rsp_status_q, rsp_status_d;
  logic [WORD_W-1:0] rsp_removed_q, rsp_removed_d;
  logic            rsp_found_q, rsp_found_d;
  logic [2:0]      rsp_index_q, rsp_index_d;
  logic [3:0]      rsp_count_q, rsp_count_d;

  logic            accept;
  kind_e           kind;
  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic [CntW-1:0] tgt;
  logic            full;
  cell_ctrl_t      ctrl;

  // cell row
  logic [WORD_W-1:0]   entry   [Capacity];
  logic [Capacity-1:0] match;
  logic                hit;
  logic [IdxW-1:0]     hit_idx;
  logic [IdxW+2:0]     hit_idx_ext;
  logic [CntW+3:0]     count_ext;

  // a new transfer is taken when the response slot is free or draining
  assign req_i.ready = !rsp_vld_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign kind        = kind_e'(req_i.kind);

  assign pos_ext = CmpW'(req_i.position);
  assign cnt_ext = CmpW'(count_q);
  assign full    = (count_q == CntW'(Capacity));

  always_comb begin
    tgt           = '0;
    count_d       = count_q;
    rsp_status_d  = ST_OK;
    rsp_removed_d = '0;
    rsp_found_d   = 1'b0;
    rsp_index_d   = '0;
    ctrl.op       = OP_HOLD;
    unique case (kind)
      KIND_INS: begin
        if (full) begin
          rsp_status_d = ST_FULL;
        end else begin
          // a position past the end appends
          tgt     = (pos_ext > cnt_ext) ? count_q : CntW'(req_i.position);
          ctrl.op = accept ? OP_INS : OP_HOLD;
          count_d = count_q + CntW'(1);
        end
      end
      KIND_DEL: begin
        if (count_q == '0) begin
          rsp_status_d = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          rsp_status_d = ST_RANGE;
        end else begin
          tgt           = CntW'(req_i.position);
          rsp_removed_d = entry[IdxW'(tgt)];
          ctrl.op       = accept ? OP_DEL : OP_HOLD;
          count_d       = count_q - CntW'(1);
        end
      end
      KIND_FIND: begin
        rsp_found_d = hit;
        rsp_index_d = hit_idx_ext[2:0];
      end
      default: begin
        // unused request kind: report the count only
      end
    endcase
    ctrl.tgt  = CNT_MAX_W'(tgt);
    ctrl.cnt  = CNT_MAX_W'(count_q);
    ctrl.word = req_i.value;
  end

  assign hit_idx_ext = (IdxW + 3)'(hit_idx);
  assign count_ext   = (CntW + 4)'(count_d);
  assign rsp_count_d = count_ext[3:0];

  // row of cells; the ends see the new word and their own word
  for (genvar k = 0; k < Capacity; k++) begin : g_cell
    logic [WORD_W-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = ctrl.word;
    end else begin : g_mid_l
      assign left = entry[k-1];
    end
    if (k == Capacity - 1) begin : g_last
      assign right = entry[k];
    end else begin : g_mid_r
      assign right = entry[k+1];
    end
    plsc_cell #(
      .CellIdx (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry[k]),
      .match_o (match[k])
    );
  end

  plsc_find #(
    .Capacity (Capacity)
  ) u_find (
    .match_i (match),
    .found_o (hit),
    .index_o (hit_idx)
  );

  // count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (accept) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  // response payload, loaded on every request transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_status_q  <= rsp_status_d;
      rsp_removed_q <= rsp_removed_d;
      rsp_found_q   <= rsp_found_d;
      rsp_index_q   <= rsp_index_d;
      rsp_count_q   <= rsp_count_d;
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.removed_value = rsp_removed_q;
  assign rsp_o.found         = rsp_found_q;
  assign rsp_o.found_index   = rsp_index_q;
  assign rsp_o.count         = rsp_count_q;

  // occupancy never passes the row length
  `PLSC_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CntW'(Capacity), "count above capacity")
  // a refused insert leaves the occupancy alone
  `PLSC_ASSERT_NEXT(a_full_hold, accept && kind == KIND_INS && full,
                    count_q == $past(count_q), "refused insert changed count")
  // every request transfer produces a pending response
  `PLSC_ASSERT_NEXT(a_rsp_loaded, accept, rsp_vld_q, "request without response")
  // a hit is only reported with an ok status
  `PLSC_ASSERT_NOW(a_found_ok, rsp_vld_q && rsp_found_q, rsp_status_q == ST_OK,
                   "hit with error status")

endmodule

/* sv/plsc_cell.sv */
module plsc_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                       clk_i,
  input  plsc_pkg::cell_ctrl_t       ctrl_i,
  input  logic [plsc_pkg::WORD_W-1:0] left_i,
  input  logic [plsc_pkg::WORD_W-1:0] right_i,
  output logic [plsc_pkg::WORD_W-1:0] entry_o,
  output logic                       match_o
);
  import plsc_pkg::*;

  localparam logic [CNT_MAX_W-1:0] K      = CNT_MAX_W'(CellIdx);
  localparam logic [CNT_MAX_W-1:0] K_NEXT = CNT_MAX_W'(CellIdx + 1);

  logic [WORD_W-1:0] entry_q, entry_d;
  logic              entry_en;

  always_comb begin
    entry_d  = entry_q;
    entry_en = 1'b0;
    unique case (ctrl_i.op)
      OP_INS: begin
        if (K == ctrl_i.tgt) begin
          entry_d  = ctrl_i.word;
          entry_en = 1'b1;
        end else if (K > ctrl_i.tgt && K <= ctrl_i.cnt) begin
          // make room: take the word from the lower neighbor
          entry_d  = left_i;
          entry_en = 1'b1;
        end
      end
      OP_DEL: begin
        if (K >= ctrl_i.tgt && K_NEXT < ctrl_i.cnt) begin
          entry_d  = right_i;
          entry_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (entry_en) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  // only occupied cells may report a hit
  assign match_o = (entry_q == ctrl_i.word) && (K < ctrl_i.cnt);

endmodule

/* sv/plsc_find.sv */
module plsc_find #(
  parameter int unsigned Capacity = plsc_pkg::CAP_DEFAULT,
  localparam int unsigned IdxW    = $clog2(Capacity)
) (
  input  logic [Capacity-1:0] match_i,
  output logic                found_o,
  output logic [IdxW-1:0]     index_o
);
  import plsc_pkg::*;

  // highest matching cell wins
  always_comb begin
    index_o = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      if (match_i[i]) begin
        index_o = IdxW'(i);
      end
    end
  end

  assign found_o = |match_i;

endmodule

/* bench/tb_positional_list_store_core.sv */
`timescale 1ns / 100ps

module tb_positional_list_store_core;
  import plsc_pkg::*;

  localparam int unsigned CAP        = CAP_DEFAULT;
  localparam int unsigned QUIET_MAX  = 2000;  // cycles without any transfer before giving up
  localparam int unsigned HOLD_LEN   = 120;   // long receiver hold-off
  localparam int unsigned HOLD_AT    = 700;   // request count that triggers the hold-off
  localparam int unsigned N_PHASES   = 50;
  localparam int unsigned PHASE_LEN  = 40;
  localparam int unsigned PRINT_MAX  = 20;

  // one request as queued for the driver; drain makes the sender wait for an empty pipe
  typedef struct packed {
    kind_e       kind;
    logic [2:0]  position;
    logic [31:0] value;
    logic        drain;
  } list_req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] removed;
    logic        found;
    logic [2:0]  index;
    logic [3:0]  count;
  } list_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  plsc_req_if req_if ();
  plsc_rsp_if rsp_if ();

  positional_list_store_core #(
    .Capacity(CAP)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // shadow copy of the list, updated once per accepted request
  logic [31:0] shadow_words [CAP];
  int unsigned shadow_cnt;

  list_req_t   pending_reqs [$];
  list_rsp_t   expected_rsps[$];

  // run statistics
  int unsigned req_acc, rsp_acc, mismatches;
  int unsigned n_ins, n_del, n_find, n_none;
  int unsigned n_full, n_empty, n_range, n_hits;

  // sender and receiver state
  list_req_t   cur_req;
  logic        offering;
  int unsigned send_gap;
  int unsigned recv_stall;
  logic        hold_done;
  int unsigned quiet;

  // apply one request to the shadow list and return the response it must produce
  function automatic list_rsp_t list_apply(list_req_t r);
    list_rsp_t   res;
    int unsigned at;
    int unsigned i;
    res = '{status: ST_OK, removed: '0, found: 1'b0, index: '0, count: '0};
    case (r.kind)
      KIND_INS: begin
        if (shadow_cnt >= CAP) begin
          res.status = ST_FULL;
        end else begin
          // a position at or past the count appends
          at = (r.position > shadow_cnt) ? shadow_cnt : r.position;
          for (i = shadow_cnt; i > at; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[at] = r.value;
          shadow_cnt++;
        end
      end
      KIND_DEL: begin
        if (shadow_cnt == 0) begin
          res.status = ST_EMPTY;
        end else if (r.position >= shadow_cnt) begin
          res.status = ST_RANGE;
        end else begin
          res.removed = shadow_words[r.position];
          for (i = r.position; i + 1 < shadow_cnt; i++) shadow_words[i] = shadow_words[i+1];
          shadow_cnt--;
        end
      end
      KIND_FIND: begin
        // last match wins, so the highest index is reported
        for (i = 0; i < shadow_cnt; i++) begin
          if (shadow_words[i] == r.value) begin
            res.found = 1'b1;
            res.index = i[2:0];
          end
        end
      end
      default: begin
      end
    endcase
    res.count = shadow_cnt[3:0];
    return res;
  endfunction

  // mostly short gaps, a few long ones, none at all in every fourth stretch of 200
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (((req_acc / 200) % 4) == 1) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_MAX) $display("%0t ERROR %s", $realtime, msg);
  endtask

  task automatic add_req(kind_e k, logic [2:0] p, logic [31:0] v, logic d);
    pending_reqs.push_back('{kind: k, position: p, value: v, drain: d});
  endtask

  // driver: presents queued requests, holds them until the transfer, then idles at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.kind     <= KIND_INS;
      req_if.position <= '0;
      req_if.value    <= '0;
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        // request transfer: predict now, in acceptance order
        expected_rsps.push_back(list_apply(cur_req));
        case (cur_req.kind)
          KIND_INS:  n_ins++;
          KIND_DEL:  n_del++;
          KIND_FIND: n_find++;
          default:   n_none++;
        endcase
        req_acc++;
        offering = 1'b0;
        send_gap = idle_len();
      end
      if (!offering) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && expected_rsps.size() != 0)) begin
          // a drain request waits until every response is back
          cur_req  = pending_reqs.pop_front();
          offering = 1'b1;
        end
      end
      req_if.valid <= offering;
      if (offering) begin
        req_if.kind     <= cur_req.kind;
        req_if.position <= cur_req.position;
        req_if.value    <= cur_req.value;
      end
    end
  end

  // monitor: checks each response transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_stall = 0;
      hold_done  = 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_acc++;
        if (expected_rsps.size() == 0) begin
          report_mismatch("response transfer with no request outstanding");
        end else begin
          automatic list_rsp_t want = expected_rsps.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch($sformatf("rsp %0d status %0d, want %0d",
                                      rsp_acc, rsp_if.status, want.status));
          if (rsp_if.removed_value !== want.removed)
            report_mismatch($sformatf("rsp %0d removed_value %h, want %h",
                                      rsp_acc, rsp_if.removed_value, want.removed));
          if (rsp_if.found !== want.found)
            report_mismatch($sformatf("rsp %0d found %b, want %b",
                                      rsp_acc, rsp_if.found, want.found));
          if (rsp_if.found_index !== want.index)
            report_mismatch($sformatf("rsp %0d found_index %0d, want %0d",
                                      rsp_acc, rsp_if.found_index, want.index));
          if (rsp_if.count !== want.count)
            report_mismatch($sformatf("rsp %0d count %0d, want %0d",
                                      rsp_acc, rsp_if.count, want.count));
          case (want.status)
            ST_FULL:  n_full++;
            ST_EMPTY: n_empty++;
            ST_RANGE: n_range++;
            default:  if (want.found) n_hits++;
          endcase
        end
        recv_stall = idle_len();
      end
      // one long hold-off so the block fills and back-pressures the sender
      if (!hold_done && req_acc >= HOLD_AT) begin
        hold_done  = 1'b1;
        recv_stall = HOLD_LEN;
      end
      if (recv_stall != 0) begin
        rsp_if.ready <= 1'b0;
        recv_stall--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // watchdog: any transfer on either side counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_MAX) begin
          $display("watchdog: no transfer for %0d cycles", quiet);
          $display("positional_list_store_core: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [31:0] pool [6];
    int unsigned bias, r, ins_lim, del_lim;
    kind_e       k;
    logic [31:0] v;

    for (int i = 0; i < CAP; i++) shadow_words[i] = '0;
    shadow_cnt = 0;
    quiet      = 0;

    // directed: empty list, appends, extremes, full list, refusals, duplicates
    add_req(KIND_FIND, 3'd0, 32'h0000_0000, 1'b0);  // find in empty list
    add_req(KIND_DEL,  3'd0, 32'h0000_0000, 1'b0);  // delete from empty list
    add_req(KIND_NONE, 3'd7, 32'hFFFF_FFFF, 1'b0);  // unused kind, ignored
    add_req(KIND_INS,  3'd7, 32'h7FFF_FFFF, 1'b0);  // past count appends
    add_req(KIND_INS,  3'd0, 32'h8000_0000, 1'b0);  // insert at head
    add_req(KIND_INS,  3'd1, 32'hFFFF_FFFF, 1'b0);  // insert in the middle
    add_req(KIND_INS,  3'd5, 32'h0000_0000, 1'b0);  // append again
    add_req(KIND_FIND, 3'd0, 32'hFFFF_FFFF, 1'b0);
    add_req(KIND_DEL,  3'd4, 32'h0000_0000, 1'b0);  // position equal to count
    add_req(KIND_DEL,  3'd7, 32'h0000_0000, 1'b0);  // position far past count
    add_req(KIND_INS,  3'd2, 32'h5555_5555, 1'b0);
    add_req(KIND_INS,  3'd6, 32'hAAAA_AAAA, 1'b0);
    add_req(KIND_INS,  3'd3, 32'h5555_5555, 1'b0);
    add_req(KIND_INS,  3'd0, 32'h5555_5555, 1'b0);  // list now full
    add_req(KIND_INS,  3'd4, 32'h1234_5678, 1'b0);  // insert into full list
    add_req(KIND_FIND, 3'd5, 32'h5555_5555, 1'b0);  // duplicates, highest index wins
    add_req(KIND_FIND, 3'd7, 32'h1234_5678, 1'b0);  // no match
    add_req(KIND_FIND, 3'd2, 32'h7FFF_FFFF, 1'b0);
    add_req(KIND_DEL,  3'd7, 32'h0000_0000, 1'b0);  // delete the last slot
    add_req(KIND_DEL,  3'd0, 32'h0000_0000, 1'b0);  // delete the head
    add_req(KIND_NONE, 3'd5, 32'h0F0F_F0F0, 1'b0);
    add_req(KIND_DEL,  3'd3, 32'hFFFF_FFFF, 1'b0);
    add_req(KIND_FIND, 3'd0, 32'h8000_0000, 1'b0);  // the old head word is still found, now at index 0

    // random: phases that fill, drain or hover, values drawn mostly from a small pool
    for (int i = 0; i < 6; i++) pool[i] = $urandom;
    for (int p = 0; p < N_PHASES; p++) begin
      bias = $urandom_range(2);
      case (bias)
        0:       begin ins_lim = 70; del_lim = 85; end
        1:       begin ins_lim = 15; del_lim = 85; end
        default: begin ins_lim = 35; del_lim = 65; end
      endcase
      for (int j = 0; j < PHASE_LEN; j++) begin
        r = $urandom_range(99);
        if (r >= 96)           k = KIND_NONE;
        else if (r < ins_lim)  k = KIND_INS;
        else if (r < del_lim)  k = KIND_DEL;
        else                   k = KIND_FIND;
        r = $urandom_range(99);
        if (r < 55) begin
          v = pool[$urandom_range(5)];
        end else if (r < 65) begin
          case ($urandom_range(3))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'hFFFF_FFFF;
            default: v = 32'h0000_0000;
          endcase
        end else begin
          v = $urandom;
        end
        // sender pauses for a full drain at the start and halfway through
        add_req(k, 3'($urandom_range(7)), v, (j == 0) && (p == 0 || p == N_PHASES / 2));
      end
    end

    // single reset at time zero
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || offering) @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (expected_rsps.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));

    $display("run: %0d requests (insert %0d, delete %0d, find %0d, unused kind %0d)",
             req_acc, n_ins, n_del, n_find, n_none);
    $display("run: refused full %0d, empty %0d, range %0d; find hits %0d; mismatches %0d",
             n_full, n_empty, n_range, n_hits, mismatches);
    if (mismatches == 0) begin
      $display("positional_list_store_core: match");
    end else begin
      $display("positional_list_store_core: mismatch");
    end
    $finish;
  end

endmodule
